[sv/rc4_key_candidate_checker_defines.svh]
// Assertion macros shared by the checker's RTL.
`ifndef RC4_KEY_CANDIDATE_CHECKER_DEFINES_SVH
`define RC4_KEY_CANDIDATE_CHECKER_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define RC4KC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define RC4KC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[sv/rc4kc_pkg.sv]
`timescale 1ns / 1ps

package rc4kc_pkg;

  typedef logic [31:0] word_t;
  typedef logic [7:0]  byte_t;
  typedef logic [11:0] mask_t;
  typedef logic [1:0]  cfg_idx_t;
  typedef logic [3:0]  ks_idx_t;

  // Permutation box geometry.
  localparam int SBOX_DEPTH = 256;
  localparam int BYTE_W     = 8;

  // Number of keystream bytes compared per key.
  localparam int NUM_KS = 12;
  localparam ks_idx_t KS_LAST = 4'd11;

  // Configuration register indexes.
  localparam cfg_idx_t REG_FRAME_ONE   = 2'd0;
  localparam cfg_idx_t REG_FRAME_TWO   = 2'd1;
  localparam cfg_idx_t REG_FRAME_THREE = 2'd2;

  // Known plaintext at the head of each frame.
  localparam byte_t KNOWN_PLAIN [NUM_KS] = '{
    8'hAA, 8'hBB, 8'hCC, 8'hDD,
    8'hEE, 8'hFF, 8'h11, 8'h22,
    8'h33, 8'h44, 8'h55, 8'h66
  };

  // Pick byte pos of a word, first byte in the top bits.
  function automatic byte_t word_byte(input word_t w, input logic [1:0] pos);
    byte_t b;
    unique case (pos)
      2'd0: b = w[31:24];
      2'd1: b = w[23:16];
      2'd2: b = w[15:8];
      default: b = w[7:0];
    endcase
    return b;
  endfunction

  // Expected keystream byte k: encrypted head byte XOR known plaintext.
  function automatic byte_t target_byte(input word_t h1, input word_t h2,
                                        input word_t h3, input ks_idx_t k);
    word_t head;
    byte_t plain;
    if (k < 4'd4) begin
      head = h1;
    end else if (k < 4'd8) begin
      head = h2;
    end else begin
      head = h3;
    end
    plain = (k <= KS_LAST) ? KNOWN_PLAIN[k] : 8'h00;
    return word_byte(head, k[1:0]) ^ plain;
  endfunction

endpackage

[sv/rc4kc_ram.sv]
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port with registered data.
// A read at the address being written returns the old contents.
module rc4kc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/rc4_key_candidate_checker.sv]
`timescale 1ns / 1ps
`include "rc4_key_candidate_checker_defines.svh"

// Tests one 32-bit RC4 key per item (first key byte in bits 31..24) against
// twelve keystream bytes derived from three frame heads written on the cfg
// port. The permutation box lives in a single-port-write RAM with a valid bit
// per entry, so it starts each key as identity without a fill sweep. Each key
// schedule swap passes through KJ, KWI and KWJ (read S[i], read S[j], two
// writes on the one write port); S[1] is then read in K0, and each of the
// eleven output steps passes through PRI, PJ, PWI and PWJ. The next item is
// accepted only after the result is loaded into the output register. The
// result sits in an output register, so a new item may start while it waits.
module rc4_key_candidate_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  rc4kc_pkg::cfg_idx_t cfg_index,
  input  rc4kc_pkg::word_t   cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  rc4kc_pkg::word_t   candidate_key,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               key_matches,
  output rc4kc_pkg::mask_t   mismatch_mask
);

  import rc4kc_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_KJ   = 4'd1;
  localparam logic [3:0] ST_KWI  = 4'd2;
  localparam logic [3:0] ST_KWJ  = 4'd3;
  localparam logic [3:0] ST_K0   = 4'd4;
  localparam logic [3:0] ST_PRI  = 4'd5;
  localparam logic [3:0] ST_PJ   = 4'd6;
  localparam logic [3:0] ST_PWI  = 4'd7;
  localparam logic [3:0] ST_PWJ  = 4'd8;
  localparam logic [3:0] ST_FIN  = 4'd9;

  logic [3:0] state;
  word_t      frame_one;
  word_t      frame_two;
  word_t      frame_three;
  word_t      key;
  byte_t      i_idx;
  byte_t      j_idx;
  byte_t      sa;
  byte_t      t_q;
  ks_idx_t    k_cnt;
  mask_t      mism;
  logic [SBOX_DEPTH-1:0] valid_bits;
  byte_t      rd_addr;
  logic       fwd_hit;
  byte_t      fwd_val;

  logic       ram_we;
  byte_t      ram_waddr;
  byte_t      ram_wdata;
  byte_t      ram_raddr;
  byte_t      ram_rdata;
  byte_t      sval;
  byte_t      i_next;
  byte_t      j_ksa;
  byte_t      j_prga;
  byte_t      t_sum;
  byte_t      out_byte;
  logic       in_acc;
  logic       out_load;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_load  = (state == ST_FIN) && (!out_valid || out_ready);

  // Entries not yet written this key read as identity; a same-cycle write
  // to the address being read is forwarded.
  assign sval = fwd_hit ? fwd_val : (valid_bits[rd_addr] ? ram_rdata : rd_addr);

  assign i_next   = 8'(i_idx + 8'd1);
  assign j_ksa    = 8'(j_idx + sval + word_byte(key, i_idx[1:0]));
  assign j_prga   = 8'(j_idx + sval);
  assign t_sum    = 8'(sa + sval);
  // S[j] receives S[i] only in PWJ, after PWI has issued the output read.
  assign out_byte = ((t_q == j_idx) && (t_q != i_idx)) ? sa : sval;

  rc4kc_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(SBOX_DEPTH)
  ) u_sbox (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // RAM port control for each sequencer step.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = i_idx;
    ram_wdata = sval;
    ram_raddr = i_idx;
    unique case (state)
      ST_IDLE: ram_raddr = '0;
      ST_KJ:   ram_raddr = j_ksa;
      ST_KWI: begin
        ram_we = 1'b1;
      end
      ST_KWJ: begin
        ram_we    = 1'b1;
        ram_waddr = j_idx;
        ram_wdata = sa;
        ram_raddr = (i_idx == 8'hFF) ? 8'd1 : i_next;
      end
      ST_PRI:  ram_raddr = i_next;
      ST_PJ:   ram_raddr = j_prga;
      ST_PWI: begin
        ram_we    = 1'b1;
        ram_raddr = t_sum;
      end
      ST_PWJ: begin
        ram_we    = 1'b1;
        ram_waddr = j_idx;
        ram_wdata = sa;
      end
      default: ram_raddr = i_idx;
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_one   <= '0;
      frame_two   <= '0;
      frame_three <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FRAME_ONE:   frame_one   <= cfg_data;
        REG_FRAME_TWO:   frame_two   <= cfg_data;
        REG_FRAME_THREE: frame_three <= cfg_data;
        default: ;
      endcase
    end
  end

  // Read tracking: address of the data now on the RAM output and forwarding.
  always_ff @(posedge clk) begin
    rd_addr <= ram_raddr;
    fwd_val <= ram_wdata;
    if (rst) begin
      fwd_hit <= 1'b0;
    end else begin
      fwd_hit <= ram_we && (ram_waddr == ram_raddr);
    end
  end

  // Written flags: cleared for each new key, set by every write.
  always_ff @(posedge clk) begin
    if (rst || in_acc) begin
      valid_bits <= '0;
    end else if (ram_we) begin
      valid_bits[ram_waddr] <= 1'b1;
    end
  end

  // Sequencer: key schedule, then keystream generation and compare.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      i_idx <= '0;
      j_idx <= '0;
      k_cnt <= '0;
      mism  <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            key   <= candidate_key;
            i_idx <= '0;
            j_idx <= '0;
            mism  <= '0;
            state <= ST_KJ;
          end
        end
        ST_KJ: begin
          sa    <= sval;
          j_idx <= j_ksa;
          state <= ST_KWI;
        end
        ST_KWI: begin
          state <= ST_KWJ;
        end
        ST_KWJ: begin
          i_idx <= i_next;
          state <= (i_idx == 8'hFF) ? ST_K0 : ST_KJ;
        end
        ST_K0: begin
          mism[0] <= (sval != target_byte(frame_one, frame_two, frame_three, 4'd0));
          i_idx   <= '0;
          j_idx   <= '0;
          k_cnt   <= 4'd1;
          state   <= ST_PRI;
        end
        ST_PRI: begin
          i_idx <= i_next;
          state <= ST_PJ;
        end
        ST_PJ: begin
          sa    <= sval;
          j_idx <= j_prga;
          state <= ST_PWI;
        end
        ST_PWI: begin
          t_q   <= t_sum;
          state <= ST_PWJ;
        end
        ST_PWJ: begin
          mism[k_cnt] <= (out_byte != target_byte(frame_one, frame_two, frame_three,
                                                  k_cnt));
          k_cnt <= 4'(k_cnt + 4'd1);
          state <= (k_cnt == KS_LAST) ? ST_FIN : ST_PRI;
        end
        ST_FIN: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Output register holds the result until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      mismatch_mask <= mism;
      key_matches   <= (mism == '0);
    end
  end

  // Checks on the sequencer and the result.
  `RC4KC_ASSERT_NEXT(a_start_ksa, in_acc, (state == ST_KJ) && (i_idx == '0) && (j_idx == '0), "key schedule did not start from index zero")
  `RC4KC_ASSERT_NOW(a_ksa_wrap, state == ST_K0, i_idx == '0, "key schedule left before all 256 swaps")
  `RC4KC_ASSERT_NOW(a_prga_count, (state == ST_PRI) || (state == ST_PWJ), (k_cnt >= 4'd1) && (k_cnt <= KS_LAST), "keystream step count out of range")
  `RC4KC_ASSERT_NOW(a_match_mask, out_valid, key_matches == (mismatch_mask == '0), "match flag disagrees with mismatch mask")

endmodule
